[rtl/core/tbrb_pkg.sv]
// tbrb_pkg: payload types, operation codes and status codes of the tcp byte ring buffer
// no dependencies; used by every file of the block
`timescale 1ns / 1ps
`default_nettype none

package tbrb_pkg;

   // fixed field widths
   localparam int unsigned OP_W   = 2;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned OFF_W  = 10;
   localparam int unsigned CNT_W  = 11;
   localparam int unsigned STAT_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_PEEK    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_POP     = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_CLAMPED = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

   // buffer size after reset
   localparam logic [CNT_W-1:0] SIZE_RESET = 11'd1024;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] push_byte;
      logic [OFF_W-1:0]  offset;
      logic [CNT_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              has_data;
      logic              last;
      logic [CNT_W-1:0]  count;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  fill_level;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/tbrb_byte_ram.sv]
// tbrb_byte_ram: single-port byte memory with registered read data
// depends on tbrb_pkg for the byte width
`timescale 1ns / 1ps
`default_nettype none

module tbrb_byte_ram #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10
) (
   input  wire                            clock,
   input  wire                            wr_en,
   input  wire                            rd_en,
   input  wire  [ADDR_W-1:0]              addr,
   input  wire  [tbrb_pkg::BYTE_W-1:0]    wr_data,
   output logic [tbrb_pkg::BYTE_W-1:0]    rd_data
);

   logic [tbrb_pkg::BYTE_W-1:0] mem [DEPTH];

   // one access per cycle, read data lands in the cycle after the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/tcp_byte_ring_buffer.sv]
// tcp_byte_ring_buffer: byte ring of one tcp stream with push, peek, release and pop
// depends on tbrb_pkg and tbrb_byte_ram
//
// Usage
//   req channel (req_valid/req_ready/req_payload) carries one operation per transfer.
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) returns the results: one for push,
//   release and empty spans, one per byte for a peek or pop span (last marks the end).
//   csr_write_enable/csr_write_data set the ring size; a write empties the ring.
// Order and throughput
//   push and release: result registered into the output in the cycle after the transfer;
//   with the receiver ready a new operation is taken every cycle.
//   peek and pop of n bytes: the span state issues the reads and each byte passes the
//   memory read and output registers, one byte per cycle from the single memory port
//   while the receiver is ready; no new operation is taken until the span is done.
// Reset
//   indices and fill level go to zero and the ring size to 1024 (clamped to DEPTH);
//   the memory itself is not cleared and needs no clearing pass.
// Stalls
//   the output register holds while rsp_ready is low; a one-byte skid stage catches
//   the byte already read from memory, and span reads pause until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module tcp_byte_ring_buffer #(
   parameter int unsigned DEPTH    = 1024,
   parameter int unsigned MAX_SPAN = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  tbrb_pkg::req_type         req_payload,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output tbrb_pkg::rsp_type               rsp_payload,
   input  wire                             csr_write_enable,
   input  wire  [tbrb_pkg::CNT_W-1:0]      csr_write_data
);

   localparam int unsigned IDX_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W  = tbrb_pkg::CNT_W;
   localparam int unsigned SUM_W  = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 2;
   localparam int unsigned SPAN_W = $clog2(MAX_SPAN + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SPAN = 1'b1;

   // ring state
   logic [CNT_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] stored_ff, stored_in;

   // span sequencer
   logic              state_ff, state_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [SPAN_W-1:0] remain_ff, remain_in;
   logic [SPAN_W-1:0] span_cnt_ff, span_cnt_in;
   logic [tbrb_pkg::STAT_W-1:0] span_stat_ff, span_stat_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              skid_last_ff, skid_last_in;
   logic [tbrb_pkg::BYTE_W-1:0] skid_data_ff, skid_data_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   tbrb_pkg::rsp_type rsp_ff, rsp_in;

   // memory port
   logic                        ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]            ram_addr;
   logic [tbrb_pkg::BYTE_W-1:0] ram_rd_data;

   // request decode
   logic              out_free, accept, issue;
   logic [CNT_W-1:0]  cap;
   logic              full;
   logic [CNT_W-1:0]  avail, n_len, n_rel, adv;
   logic [SPAN_W-1:0] n_span;
   logic [tbrb_pkg::STAT_W-1:0] stat_span, stat_rel;
   logic [SUM_W-1:0]  start_sum, rd_adv_sum, wr_adv_sum, addr_next_sum;

   function automatic logic [SUM_W-1:0] wrap_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b,
                                                input logic [SUM_W-1:0] lim);
      logic [SUM_W-1:0] s;
      s = a + b;
      return (s >= lim) ? s - lim : s;
   endfunction

   // effective capacity, clamped to 1..DEPTH
   always_comb begin
      if (size_ff == '0) begin
         cap = CNT_W'(1);
      end else if (SUM_W'(size_ff) > SUM_W'(DEPTH)) begin
         cap = CNT_W'(DEPTH);
      end else begin
         cap = size_ff;
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // span and release clamping
   always_comb begin
      full = (stored_ff >= cap);
      if (req_payload.operation == tbrb_pkg::OP_PEEK) begin
         avail = (CNT_W'(req_payload.offset) <= stored_ff) ?
                 stored_ff - CNT_W'(req_payload.offset) : '0;
      end else begin
         avail = stored_ff;
      end
      n_len = (req_payload.length < avail) ? req_payload.length : avail;
      if (n_len > CNT_W'(MAX_SPAN)) begin
         n_span = SPAN_W'(MAX_SPAN);
      end else begin
         n_span = n_len[SPAN_W-1:0];
      end
      stat_span = (CNT_W'(n_span) < req_payload.length) ?
                  tbrb_pkg::ST_CLAMPED : tbrb_pkg::ST_OK;
      n_rel    = (req_payload.length < stored_ff) ? req_payload.length : stored_ff;
      stat_rel = (n_rel < req_payload.length) ? tbrb_pkg::ST_CLAMPED : tbrb_pkg::ST_OK;
      adv      = (req_payload.operation == tbrb_pkg::OP_RELEASE) ? n_rel : CNT_W'(n_span);
   end

   // index arithmetic with wrap at the capacity
   assign start_sum = wrap_add(SUM_W'(rd_idx_ff),
                               (req_payload.operation == tbrb_pkg::OP_PEEK) ?
                               SUM_W'(req_payload.offset) : '0,
                               SUM_W'(cap));
   assign rd_adv_sum    = wrap_add(SUM_W'(rd_idx_ff), SUM_W'(adv), SUM_W'(cap));
   assign wr_adv_sum    = wrap_add(SUM_W'(wr_idx_ff), SUM_W'(1), SUM_W'(cap));
   assign addr_next_sum = wrap_add(SUM_W'(addr_ff), SUM_W'(1), SUM_W'(cap));

   // span read issue: only when the byte can land in the output or the skid stage
   assign issue = (state_ff == S_SPAN) && (remain_ff != '0) && !skid_valid_ff &&
                  (!pend_ff || out_free);

   // memory port: push writes in idle, span reads in the span state
   assign ram_wr_en = accept && (req_payload.operation == tbrb_pkg::OP_PUSH) && !full;
   assign ram_rd_en = issue;
   assign ram_addr  = (state_ff == S_SPAN) ? addr_ff : wr_idx_ff;

   // next state
   always_comb begin
      size_in       = size_ff;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      stored_in     = stored_ff;
      state_in      = state_ff;
      addr_in       = addr_ff;
      remain_in     = remain_ff;
      span_cnt_in   = span_cnt_ff;
      span_stat_in  = span_stat_ff;
      pend_in       = 1'b0;
      pend_last_in  = pend_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_last_in  = skid_last_ff;
      skid_data_in  = skid_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      // idle: take one operation
      if (accept) begin
         rsp_in.data_byte = '0;
         rsp_in.has_data  = 1'b0;
         rsp_in.last      = 1'b1;
         rsp_valid_in     = 1'b1;
         unique case (req_payload.operation)
            tbrb_pkg::OP_PUSH: begin
               if (full) begin
                  rsp_in.count  = '0;
                  rsp_in.status = tbrb_pkg::ST_FULL;
               end else begin
                  wr_idx_in     = wr_adv_sum[IDX_W-1:0];
                  stored_in     = stored_ff + CNT_W'(1);
                  rsp_in.count  = CNT_W'(1);
                  rsp_in.status = tbrb_pkg::ST_OK;
               end
            end
            tbrb_pkg::OP_RELEASE: begin
               rd_idx_in     = rd_adv_sum[IDX_W-1:0];
               stored_in     = stored_ff - n_rel;
               rsp_in.count  = n_rel;
               rsp_in.status = stat_rel;
            end
            tbrb_pkg::OP_PEEK,
            tbrb_pkg::OP_POP: begin
               rsp_in.count  = '0;
               rsp_in.status = stat_span;
               if (n_span != '0) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_SPAN;
                  addr_in      = start_sum[IDX_W-1:0];
                  remain_in    = n_span;
                  span_cnt_in  = n_span;
                  span_stat_in = stat_span;
                  if (req_payload.operation == tbrb_pkg::OP_POP) begin
                     rd_idx_in = rd_adv_sum[IDX_W-1:0];
                     stored_in = stored_ff - CNT_W'(n_span);
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
         rsp_in.fill_level = stored_in;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      // span: issue reads, move bytes to the output
      if (state_ff == S_SPAN) begin
         if (issue) begin
            remain_in    = remain_ff - SPAN_W'(1);
            addr_in      = addr_next_sum[IDX_W-1:0];
            pend_in      = 1'b1;
            pend_last_in = (remain_ff == SPAN_W'(1));
         end
         if (out_free && (skid_valid_ff || pend_ff)) begin
            rsp_valid_in      = 1'b1;
            rsp_in.data_byte  = skid_valid_ff ? skid_data_ff : ram_rd_data;
            rsp_in.last       = skid_valid_ff ? skid_last_ff : pend_last_ff;
            rsp_in.has_data   = 1'b1;
            rsp_in.count      = CNT_W'(span_cnt_ff);
            rsp_in.status     = span_stat_ff;
            rsp_in.fill_level = stored_ff;
         end
         // skid: catch the read byte while the output is stalled
         if (pend_ff && !out_free) begin
            skid_valid_in = 1'b1;
            skid_data_in  = ram_rd_data;
            skid_last_in  = pend_last_ff;
         end else if (skid_valid_ff && out_free) begin
            skid_valid_in = 1'b0;
         end
         if ((remain_ff == '0) && !pend_ff && !skid_valid_ff) begin
            state_in = S_IDLE;
         end
      end

      // register write empties the ring
      if (csr_write_enable) begin
         size_in   = csr_write_data;
         wr_idx_in = '0;
         rd_idx_in = '0;
         stored_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= tbrb_pkg::SIZE_RESET;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         stored_ff     <= '0;
         state_ff      <= S_IDLE;
         remain_ff     <= '0;
         pend_ff       <= 1'b0;
         skid_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         size_ff       <= size_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         stored_ff     <= stored_in;
         state_ff      <= state_in;
         remain_ff     <= remain_in;
         pend_ff       <= pend_in;
         skid_valid_ff <= skid_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      span_cnt_ff  <= span_cnt_in;
      span_stat_ff <= span_stat_in;
      pend_last_ff <= pend_last_in;
      skid_last_ff <= skid_last_in;
      skid_data_ff <= skid_data_in;
      rsp_ff       <= rsp_in;
   end

   // byte store
   tbrb_byte_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (req_payload.push_byte),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/tbrb_checker.sv]
// tbrb_checker: port-level assertions on the result channel of tcp_byte_ring_buffer
// depends on tbrb_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module tbrb_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire tbrb_pkg::rsp_type rsp_payload
);

   // a stalled result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // nothing is shown in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a result without a byte is always the only one of its operation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.has_data |-> rsp_payload.last)
      else $error("byte-less result not marked last");

   // a delivered byte carries a nonzero count and a status other than full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.has_data |->
         rsp_payload.count != '0 && rsp_payload.status != tbrb_pkg::ST_FULL)
      else $error("byte delivered with bad count or status");

   // a rejected push reports zero bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == tbrb_pkg::ST_FULL |-> rsp_payload.count == '0)
      else $error("rejected push with nonzero count");

endmodule

bind tcp_byte_ring_buffer tbrb_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[sim/tcp_byte_ring_buffer_test.sv]
`timescale 1ns / 1ps
// tcp_byte_ring_buffer_test: self-checking bench for the tcp byte ring buffer, a directed
// table followed by random push/peek/release/pop traffic checked against an in-bench ring
// depends on tbrb_pkg and tcp_byte_ring_buffer
module tcp_byte_ring_buffer_test;

   localparam int unsigned OP_W          = tbrb_pkg::OP_W;
   localparam int unsigned BYTE_W        = tbrb_pkg::BYTE_W;
   localparam int unsigned OFF_W         = tbrb_pkg::OFF_W;
   localparam int unsigned CNT_W         = tbrb_pkg::CNT_W;
   localparam int unsigned STAT_W        = tbrb_pkg::STAT_W;
   localparam int unsigned RING_DEPTH    = 1024;
   localparam int unsigned SPAN_MAX      = 64;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned STALL_LIMIT   = 1000;
   localparam int          PHASE_ITEMS   = 70;

   // one row of the directed table: a size write or an operation
   typedef struct {
      bit                          is_csr;
      logic [CNT_W-1:0]            size_value;
      tbrb_pkg::req_type           op;
      bit                          typed;
      tbrb_pkg::rsp_type           want;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   tbrb_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tbrb_pkg::rsp_type rsp_payload;
   logic              csr_write_enable;
   logic [CNT_W-1:0]  csr_write_data;

   // ring model state
   logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
   logic [OFF_W-1:0]  wr_ptr;
   logic [OFF_W-1:0]  rd_ptr;
   logic [CNT_W-1:0]  fill;
   logic [CNT_W-1:0]  ring_size;

   tbrb_pkg::rsp_type awaited_rsp_q[$];
   tbrb_pkg::rsp_type op_results[$];
   bit                cur_typed;
   tbrb_pkg::rsp_type cur_want;
   int                error_count;
   int                idle_cycles;
   int                push_run;
   int                send_idle_pct = 17;
   int                recv_idle_pct = 45;

   tcp_byte_ring_buffer #(
      .DEPTH(RING_DEPTH),
      .MAX_SPAN(SPAN_MAX)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ring capacity in use
   function automatic int unsigned ring_cap();
      if (ring_size < 1) return 1;
      if (ring_size > RING_DEPTH) return RING_DEPTH;
      return ring_size;
   endfunction

   function automatic int unsigned ring_wrap(input int unsigned idx, input int unsigned add,
                                             input int unsigned cap);
      int unsigned s;
      s = idx + add;
      if (s >= cap) s = s - cap;
      if (s >= cap) s = s % cap;
      return s;
   endfunction

   // advance the ring model by one operation, leaving its results in op_results
   task automatic apply_ring_op(input tbrb_pkg::req_type r);
      tbrb_pkg::rsp_type res;
      int unsigned       cap;
      int unsigned       avail;
      int unsigned       n;
      int unsigned       pos;
      int unsigned       off;
      int unsigned       i;
      cap = ring_cap();
      off = r.offset;
      res = '0;
      res.last = 1'b1;
      op_results.delete();
      case (r.operation)
         tbrb_pkg::OP_PUSH: begin
            // a full ring drops the byte
            if (fill >= cap) begin
               res.status = tbrb_pkg::ST_FULL;
            end else begin
               ring_mem[wr_ptr] = r.push_byte;
               wr_ptr = OFF_W'(ring_wrap(wr_ptr, 1, cap));
               fill = fill + 1'b1;
               res.count = 11'd1;
            end
            res.fill_level = fill;
            op_results.push_back(res);
         end
         tbrb_pkg::OP_RELEASE: begin
            n = (r.length < fill) ? r.length : fill;
            res.status = (n < r.length) ? tbrb_pkg::ST_CLAMPED : tbrb_pkg::ST_OK;
            rd_ptr = OFF_W'(ring_wrap(rd_ptr, n, cap));
            fill = CNT_W'(fill - n);
            res.count = CNT_W'(n);
            res.fill_level = fill;
            op_results.push_back(res);
         end
         default: begin
            // peek skips offset bytes, pop always starts at the read pointer
            if (r.operation == tbrb_pkg::OP_PEEK) begin
               avail = (off <= fill) ? fill - off : 0;
            end else begin
               off = 0;
               avail = fill;
            end
            n = (r.length < avail) ? r.length : avail;
            if (n > SPAN_MAX) n = SPAN_MAX;
            res.status = (n < r.length) ? tbrb_pkg::ST_CLAMPED : tbrb_pkg::ST_OK;
            res.count = CNT_W'(n);
            pos = ring_wrap(rd_ptr, off, cap);
            if (r.operation == tbrb_pkg::OP_POP) begin
               rd_ptr = OFF_W'(ring_wrap(rd_ptr, n, cap));
               fill = CNT_W'(fill - n);
            end
            res.fill_level = fill;
            if (n == 0) op_results.push_back(res);
            for (i = 0; i < n; i++) begin
               res.data_byte = ring_mem[pos];
               res.has_data = 1'b1;
               res.last = (i + 1 == n);
               op_results.push_back(res);
               pos = ring_wrap(pos, 1, cap);
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_result(input tbrb_pkg::rsp_type got, input tbrb_pkg::rsp_type want);
      if (got.data_byte !== want.data_byte)
         report_mismatch("data_byte", got.data_byte, want.data_byte);
      if (got.has_data !== want.has_data)
         report_mismatch("has_data", got.has_data, want.has_data);
      if (got.last !== want.last)
         report_mismatch("last", got.last, want.last);
      if (got.count !== want.count)
         report_mismatch("count", got.count, want.count);
      if (got.status !== want.status)
         report_mismatch("status", got.status, want.status);
      if (got.fill_level !== want.fill_level)
         report_mismatch("fill_level", got.fill_level, want.fill_level);
   endtask

   // transfer monitor, result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp_q.size() == 0)
               report_mismatch("result with nothing awaited", rsp_payload.data_byte, 0);
            else
               check_result(rsp_payload, awaited_rsp_q.pop_front());
         end
         if (req_valid && req_ready) begin
            apply_ring_op(req_payload);
            if (cur_typed)
               awaited_rsp_q.push_back(cur_want);
            else
               foreach (op_results[i]) awaited_rsp_q.push_back(op_results[i]);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   // one request transfer, with a random gap in front of it
   task automatic send_op(input tbrb_pkg::req_type r, input bit typed,
                          input tbrb_pkg::rsp_type want);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_payload <= r;
      req_valid <= 1'b1;
      cur_typed = typed;
      cur_want = want;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   // hold off requests until every awaited result has come, then settle
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited_rsp_q.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   // size write on an idle block; the ring empties
   task automatic write_ring_size(input logic [CNT_W-1:0] value);
      drain_results(SETTLE_CYCLES);
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      ring_size = value;
      wr_ptr = '0;
      rd_ptr = '0;
      fill = '0;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random operation: push runs and spans sized around the fill level, plus noise
   task automatic pick_ring_op(output tbrb_pkg::req_type r);
      int unsigned roll;
      int unsigned lim;
      roll = $urandom_range(99);
      r.push_byte = BYTE_W'($urandom_range(255));
      r.offset = OFF_W'($urandom_range(1023));
      r.length = CNT_W'($urandom_range(1024));
      if (push_run > 0) begin
         push_run--;
         r.operation = tbrb_pkg::OP_PUSH;
      end else if (roll < 12) begin
         push_run = $urandom_range(80);
         r.operation = tbrb_pkg::OP_PUSH;
      end else if (roll < 35) begin
         r.operation = tbrb_pkg::OP_PUSH;
      end else if (roll < 60) begin
         r.operation = tbrb_pkg::OP_PEEK;
      end else if (roll < 72) begin
         r.operation = tbrb_pkg::OP_RELEASE;
      end else begin
         r.operation = tbrb_pkg::OP_POP;
      end
      if ($urandom_range(99) < 80) begin
         lim = fill + 2;
         r.offset = OFF_W'($urandom_range(lim > 1023 ? 1023 : lim));
         if ($urandom_range(2) == 0)
            r.length = CNT_W'($urandom_range(lim > 1024 ? 1024 : lim));
         else
            r.length = CNT_W'($urandom_range(8));
      end
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct,
                                   input logic [CNT_W-1:0] size, input int hold_at);
      tbrb_pkg::req_type r;
      int                k;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_ring_size(size);
      push_run = 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
         if (k == hold_at) drain_results(0);
         pick_ring_op(r);
         send_op(r, 1'b0, '0);
      end
   endtask

   function automatic plan_row_type op_row(input logic [OP_W-1:0] op,
                                           input logic [BYTE_W-1:0] b,
                                           input logic [OFF_W-1:0] off,
                                           input logic [CNT_W-1:0] len);
      plan_row_type row;
      row.is_csr = 1'b0;
      row.size_value = '0;
      row.op = '{operation: op, push_byte: b, offset: off, length: len};
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   // single result with no data byte, typed in
   function automatic plan_row_type typed_row(input logic [OP_W-1:0] op,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [OFF_W-1:0] off,
                                              input logic [CNT_W-1:0] len,
                                              input logic [CNT_W-1:0] cnt,
                                              input logic [STAT_W-1:0] st,
                                              input logic [CNT_W-1:0] lvl);
      plan_row_type row;
      row = op_row(op, b, off, len);
      row.typed = 1'b1;
      row.want = '{data_byte: '0, has_data: 1'b0, last: 1'b1, count: cnt, status: st,
                   fill_level: lvl};
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [CNT_W-1:0] value);
      plan_row_type row;
      row = op_row(tbrb_pkg::OP_PUSH, '0, '0, '0);
      row.is_csr = 1'b1;
      row.size_value = value;
      return row;
   endfunction

   initial begin
      plan_row_type plan[$];
      int           k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = tbrb_pkg::SIZE_RESET;
      ring_size = tbrb_pkg::SIZE_RESET;
      wr_ptr = '0;
      rd_ptr = '0;
      fill = '0;
      cur_typed = 1'b0;
      cur_want = '0;
      error_count = 0;
      idle_cycles = 0;
      push_run = 0;

      // empty ring at reset size
      plan.push_back(typed_row(tbrb_pkg::OP_POP, 8'h00, 10'd0, 11'd0,
                               11'd0, tbrb_pkg::ST_OK, 11'd0));
      plan.push_back(typed_row(tbrb_pkg::OP_PEEK, 8'h00, 10'd0, 11'd5,
                               11'd0, tbrb_pkg::ST_CLAMPED, 11'd0));
      plan.push_back(typed_row(tbrb_pkg::OP_RELEASE, 8'h00, 10'd0, 11'd1024,
                               11'd0, tbrb_pkg::ST_CLAMPED, 11'd0));
      // byte extremes
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h00, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd1));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'hFF, 10'h3FF, 11'h7FF,
                               11'd1, tbrb_pkg::ST_OK, 11'd2));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'hA5, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd3));
      plan.push_back(op_row(tbrb_pkg::OP_PEEK, 8'h00, 10'd0, 11'd3));
      // offset past the stored data, and offset exactly at it
      plan.push_back(typed_row(tbrb_pkg::OP_PEEK, 8'h00, 10'd1023, 11'd1,
                               11'd0, tbrb_pkg::ST_CLAMPED, 11'd3));
      plan.push_back(typed_row(tbrb_pkg::OP_PEEK, 8'h00, 10'd3, 11'd0,
                               11'd0, tbrb_pkg::ST_OK, 11'd3));
      plan.push_back(op_row(tbrb_pkg::OP_PEEK, 8'h00, 10'd1, 11'd1024));
      plan.push_back(op_row(tbrb_pkg::OP_POP, 8'h00, 10'd0, 11'd1));
      plan.push_back(typed_row(tbrb_pkg::OP_RELEASE, 8'h00, 10'd0, 11'd1,
                               11'd1, tbrb_pkg::ST_OK, 11'd1));
      plan.push_back(op_row(tbrb_pkg::OP_POP, 8'h00, 10'd0, 11'd1024));
      // small ring: full, wrap on push and on peek
      plan.push_back(csr_row(11'd4));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h11, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd1));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h22, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd2));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h33, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd3));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h44, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd4));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h55, 10'd0, 11'd0,
                               11'd0, tbrb_pkg::ST_FULL, 11'd4));
      plan.push_back(op_row(tbrb_pkg::OP_POP, 8'h00, 10'd0, 11'd2));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h66, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd3));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h77, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd4));
      plan.push_back(op_row(tbrb_pkg::OP_PEEK, 8'h00, 10'd1, 11'd3));
      plan.push_back(op_row(tbrb_pkg::OP_POP, 8'h00, 10'd0, 11'd64));
      // one-slot ring
      plan.push_back(csr_row(11'd1));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h80, 10'd0, 11'd0,
                               11'd1, tbrb_pkg::ST_OK, 11'd1));
      plan.push_back(typed_row(tbrb_pkg::OP_PUSH, 8'h01, 10'd0, 11'd0,
                               11'd0, tbrb_pkg::ST_FULL, 11'd1));
      plan.push_back(op_row(tbrb_pkg::OP_POP, 8'h00, 10'd0, 11'd1));

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (k = 0; k < plan.size(); k++) begin
         if (plan[k].is_csr)
            write_ring_size(plan[k].size_value);
         else
            send_op(plan[k].op, plan[k].typed, plan[k].want);
      end

      // random traffic: sender light and receiver heavy idling, then swapped, then none
      run_random_phase(17, 45, 11'd13, -1);
      run_random_phase(45, 17, 11'd1024, PHASE_ITEMS / 2);
      run_random_phase(0, 0, CNT_W'($urandom_range(100, 2)), -1);

      drain_results(SETTLE_CYCLES);
      if (awaited_rsp_q.size() != 0)
         report_mismatch("results never delivered", awaited_rsp_q.size(), 0);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
